// ===== src/sfd_pkg.sv =====
// sfd_pkg: shared constants and types for the status frame deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

   localparam int FRAME_LEN   = 19;
   localparam int PAY_FIRST   = 2;
   localparam int PAY_LAST    = 14;
   localparam int SUM_LAST    = 15;
   localparam int SUM_POS     = 16;
   localparam int TRL_FIRST   = 17;
   localparam int TRL_LAST    = 18;
   localparam int PAY_COUNT   = PAY_LAST - PAY_FIRST + 1;
   localparam int IDX_W       = 5;
   localparam int PAY_IDX_W   = 4;

   localparam logic [7:0] HDR_BYTE = 8'hee;
   localparam logic [7:0] TRL_BYTE = 8'h88;

   localparam int FREQ_W = 22;
   localparam int ATTN_W = 12;

   localparam logic [1:0] MODE_KEYPAD   = 2'd0;
   localparam logic [1:0] MODE_RS232    = 2'd1;
   localparam logic [1:0] MODE_ETHERNET = 2'd2;

   // payload bytes b2..b14 of one good frame, entry 0 holds b2
   typedef logic [PAY_COUNT-1:0][7:0] frame_rec_type;

   // queue status seen by the front end and back end
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage : sfd_pkg

`default_nettype wire

// ===== src/sfd_front.sv =====
// sfd_front: byte intake, frame hunt, running checksum and trailer check
// depends on sfd_pkg; pushes one record per good frame into sfd_queue
`timescale 1ns / 1ps
`default_nettype none

module sfd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_rx_byte,
   input  wire sfd_pkg::queue_stat_type q_stat,
   output logic                       push,
   output sfd_pkg::frame_rec_type     push_rec
);
   import sfd_pkg::*;

   logic                  in_frame_ff, in_frame_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  sum_ok_ff, sum_ok_in;
   logic                  trl_ok_ff, trl_ok_in;
   frame_rec_type         pay_ff;
   logic                  take;
   logic [IDX_W-1:0]      nidx;
   logic                  store;
   logic [PAY_IDX_W-1:0]  pay_sel;
   logic                  frame_good;

   assign req_ready = ~q_stat.full;
   assign take      = req_valid & req_ready;
   assign nidx      = idx_ff + IDX_W'(1);
   assign pay_sel   = PAY_IDX_W'(nidx - IDX_W'(PAY_FIRST));
   assign store     = take & in_frame_ff & (nidx >= IDX_W'(PAY_FIRST))
                      & (nidx <= IDX_W'(PAY_LAST));

   always_comb begin
      in_frame_in = in_frame_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      sum_ok_in   = sum_ok_ff;
      trl_ok_in   = trl_ok_ff;
      frame_good  = 1'b0;
      if (take) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == HDR_BYTE) begin
               in_frame_in = 1'b1;
               idx_in      = '0;
               sum_in      = '0;
            end
         end else begin
            idx_in = nidx;
            if (nidx == IDX_W'(1)) begin
               if (req_rx_byte != HDR_BYTE) in_frame_in = 1'b0;
            end else if (nidx <= IDX_W'(SUM_LAST)) begin
               sum_in = sum_ff + req_rx_byte;
            end else if (nidx == IDX_W'(SUM_POS)) begin
               sum_ok_in = (sum_ff == req_rx_byte);
            end else if (nidx == IDX_W'(TRL_FIRST)) begin
               trl_ok_in = (req_rx_byte == TRL_BYTE);
            end else if (nidx == IDX_W'(TRL_LAST)) begin
               in_frame_in = 1'b0;
               frame_good  = sum_ok_ff & trl_ok_ff & (req_rx_byte == TRL_BYTE);
            end else begin
               in_frame_in = 1'b0;
               idx_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         idx_ff      <= '0;
         sum_ff      <= '0;
         sum_ok_ff   <= 1'b0;
         trl_ok_ff   <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         sum_ok_ff   <= sum_ok_in;
         trl_ok_ff   <= trl_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) pay_ff[pay_sel] <= req_rx_byte;
   end

   assign push     = frame_good;
   assign push_rec = pay_ff;

endmodule : sfd_front

`default_nettype wire

// ===== src/sfd_queue.sv =====
// sfd_queue: two-entry queue of frame records between front and back end
// depends on sfd_pkg for the record and status types
`timescale 1ns / 1ps
`default_nettype none

module sfd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sfd_pkg::frame_rec_type push_rec,
   input  wire logic                  pop,
   output sfd_pkg::frame_rec_type     head_rec,
   output sfd_pkg::queue_stat_type    q_stat
);
   import sfd_pkg::*;

   frame_rec_type  slot_ff [2];
   logic           wptr_ff, wptr_in;
   logic           rptr_ff, rptr_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.empty = (cnt_ff == 2'd0);
   assign do_push      = push & ~q_stat.full;
   assign do_pop       = pop & ~q_stat.empty;
   assign head_rec     = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_rec;
   end

endmodule : sfd_queue

`default_nettype wire

// ===== src/sfd_back.sv =====
// sfd_back: decodes frame records into frequency, attenuations and flags
// depends on sfd_pkg; two register stages, the second is the output register
`timescale 1ns / 1ps
`default_nettype none

module sfd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfd_pkg::queue_stat_type q_stat,
   input  wire sfd_pkg::frame_rec_type head_rec,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [21:0]                rsp_freq_tenths,
   output logic [11:0]                rsp_attn_one_tenths,
   output logic [11:0]                rsp_attn_two_tenths,
   output logic [11:0]                rsp_attn_three_tenths,
   output logic                       rsp_pll_on,
   output logic [1:0]                 rsp_control_mode
);
   import sfd_pkg::*;

   // stage a: partial frequency sums, attenuations, pll flag and mode
   logic              a_valid_ff;
   logic [FREQ_W-1:0] a_hi_ff, a_hi_in;
   logic [FREQ_W-1:0] a_lo_ff, a_lo_in;
   logic [ATTN_W-1:0] a_at1_ff, a_at1_in;
   logic [ATTN_W-1:0] a_at2_ff, a_at2_in;
   logic [ATTN_W-1:0] a_at3_ff, a_at3_in;
   logic              a_pll_ff, a_pll_in;
   logic [1:0]        a_mode_ff, a_mode_in;
   // stage b: output register
   logic              b_valid_ff;
   logic [FREQ_W-1:0] b_freq_ff;
   logic [ATTN_W-1:0] b_at1_ff, b_at2_ff, b_at3_ff;
   logic              b_pll_ff;
   logic [1:0]        b_mode_ff;
   logic              b_load, a_load;

   function automatic logic [ATTN_W-1:0] pair_tenths(input logic [7:0] hi,
                                                     input logic [7:0] lo);
      pair_tenths = {4'd0, hi} * ATTN_W'(10) + {4'd0, lo};
   endfunction

   assign b_load = a_valid_ff & (~b_valid_ff | rsp_ready);
   assign a_load = ~a_valid_ff | b_load;
   assign pop    = a_load & ~q_stat.empty;

   always_comb begin
      a_hi_in   = {14'd0, head_rec[0]} * FREQ_W'(10000)
                + {14'd0, head_rec[1]} * FREQ_W'(1000);
      a_lo_in   = {14'd0, head_rec[2]} * FREQ_W'(100)
                + {14'd0, head_rec[3]} * FREQ_W'(10)
                + {14'd0, head_rec[4]};
      a_at1_in  = pair_tenths(head_rec[5], head_rec[6]);
      a_at2_in  = pair_tenths(head_rec[7], head_rec[8]);
      a_at3_in  = pair_tenths(head_rec[9], head_rec[10]);
      a_pll_in  = (head_rec[11] != 8'd0);
      case (head_rec[12])
         8'd1:    a_mode_in = MODE_RS232;
         8'd2:    a_mode_in = MODE_ETHERNET;
         default: a_mode_in = MODE_KEYPAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_load) a_valid_ff <= ~q_stat.empty;
         if (b_load) begin
            b_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_hi_ff   <= a_hi_in;
         a_lo_ff   <= a_lo_in;
         a_at1_ff  <= a_at1_in;
         a_at2_ff  <= a_at2_in;
         a_at3_ff  <= a_at3_in;
         a_pll_ff  <= a_pll_in;
         a_mode_ff <= a_mode_in;
      end
      if (b_load) begin
         b_freq_ff <= a_hi_ff + a_lo_ff;
         b_at1_ff  <= a_at1_ff;
         b_at2_ff  <= a_at2_ff;
         b_at3_ff  <= a_at3_ff;
         b_pll_ff  <= a_pll_ff;
         b_mode_ff <= a_mode_ff;
      end
   end

   assign rsp_valid             = b_valid_ff;
   assign rsp_freq_tenths       = b_freq_ff;
   assign rsp_attn_one_tenths   = b_at1_ff;
   assign rsp_attn_two_tenths   = b_at2_ff;
   assign rsp_attn_three_tenths = b_at3_ff;
   assign rsp_pll_on            = b_pll_ff;
   assign rsp_control_mode      = b_mode_ff;

endmodule : sfd_back

`default_nettype wire

// ===== src/status_frame_deframer_unit.sv =====
// status_frame_deframer_unit: one received byte per beat, one result beat per good frame
// path: the result beat follows the last trailer beat through the queue slot, decode stage and output reg
// throughput: one byte beat per cycle; the front end stalls only when the two-entry queue is full
// reset: synchronous, active high; clears frame hunt, checksum, queue, decode-stage valid and output valid
// depends on sfd_pkg, sfd_front, sfd_queue and sfd_back
`timescale 1ns / 1ps
`default_nettype none

module status_frame_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [21:0]      rsp_freq_tenths,
   output logic [11:0]      rsp_attn_one_tenths,
   output logic [11:0]      rsp_attn_two_tenths,
   output logic [11:0]      rsp_attn_three_tenths,
   output logic             rsp_pll_on,
   output logic [1:0]       rsp_control_mode
);
   import sfd_pkg::*;

   queue_stat_type q_stat;
   frame_rec_type  push_rec;
   frame_rec_type  head_rec;
   logic           push;
   logic           pop;

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_stat      (q_stat),
      .push        (push),
      .push_rec    (push_rec)
   );

   sfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_stat   (q_stat)
   );

   sfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_stat                (q_stat),
      .head_rec              (head_rec),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_freq_tenths       (rsp_freq_tenths),
      .rsp_attn_one_tenths   (rsp_attn_one_tenths),
      .rsp_attn_two_tenths   (rsp_attn_two_tenths),
      .rsp_attn_three_tenths (rsp_attn_three_tenths),
      .rsp_pll_on            (rsp_pll_on),
      .rsp_control_mode      (rsp_control_mode)
   );

endmodule : status_frame_deframer_unit

`default_nettype wire
